// File: rtl/pcmfc_pkg.sv
// ---------------------------------------------------------------------------
// pcmfc_pkg
// Shared types, register indexes and helpers for the PCM sample converter.
// ---------------------------------------------------------------------------
package pcmfc_pkg;

  // conversion modes
  typedef enum logic [1:0] {
    MODE_I2I = 2'd0,
    MODE_I2F = 2'd1,
    MODE_F2I = 2'd2
  } mode_t;

  // width codes
  localparam logic [1:0] WCODE_8  = 2'd0;
  localparam logic [1:0] WCODE_16 = 2'd1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_CODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_SGN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_SGN  = 3'd4;
  localparam int unsigned CFG_DATA_W = 2;

  // float layout
  localparam logic [7:0] EXP_BIAS = 8'd127;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] src_width_code;
    logic [1:0] dst_width_code;
    logic       src_is_signed;
    logic       dst_is_signed;
  } cfg_t;

  // middle stage contents
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] direct;   // integer result or zero
    logic        sign;     // int to float: sign
    logic [31:0] mag;      // int to float: magnitude
    logic [4:0]  msb;      // int to float: leading one position
    logic [7:0]  wm1;      // int to float: source width minus one
  } mid_t;

  // sample width minus one
  function automatic logic [4:0] width_m1(input logic [1:0] code);
    case (code)
      WCODE_8:  width_m1 = 5'd7;
      WCODE_16: width_m1 = 5'd15;
      default:  width_m1 = 5'd31;
    endcase
  endfunction

  // mask of the low width bits
  function automatic logic [31:0] width_mask(input logic [1:0] code);
    case (code)
      WCODE_8:  width_mask = 32'h0000_00FF;
      WCODE_16: width_mask = 32'h0000_FFFF;
      default:  width_mask = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

// File: rtl/pcmfc_in_if.sv
// ---------------------------------------------------------------------------
// pcmfc_in_if
// Input sample channel: valid, ready and the sample bits.
// ---------------------------------------------------------------------------
interface pcmfc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] in_sample;

  modport source (output valid, output in_sample, input ready);
  modport sink   (input valid, input in_sample, output ready);
endinterface

// File: rtl/pcmfc_out_if.sv
// ---------------------------------------------------------------------------
// pcmfc_out_if
// Result sample channel: valid, ready and the converted bits.
// ---------------------------------------------------------------------------
interface pcmfc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

// File: rtl/pcmfc_cfg.sv
// ---------------------------------------------------------------------------
// pcmfc_cfg
// Configuration register file, write only.
// ---------------------------------------------------------------------------
module pcmfc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pcmfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pcmfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output pcmfc_pkg::cfg_t                cfg
);
  import pcmfc_pkg::*;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_I2I;
      cfg.src_width_code <= WCODE_16;
      cfg.dst_width_code <= WCODE_16;
      cfg.src_is_signed  <= 1'b1;
      cfg.dst_is_signed  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:     cfg.mode           <= cfg_wdata;
        CFG_SRC_CODE: cfg.src_width_code <= cfg_wdata;
        CFG_DST_CODE: cfg.dst_width_code <= cfg_wdata;
        CFG_SRC_SGN:  cfg.src_is_signed  <= cfg_wdata[0];
        CFG_DST_SGN:  cfg.dst_is_signed  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end
endmodule

// File: rtl/pcmfc_prep.sv
// ---------------------------------------------------------------------------
// pcmfc_prep
// First logic stage: integer rescale, float to integer, and the magnitude
// and leading one search for integer to float.
// ---------------------------------------------------------------------------
module pcmfc_prep (
  input  logic [31:0]     sample,
  input  pcmfc_pkg::cfg_t cfg,
  output pcmfc_pkg::mid_t mid
);
  import pcmfc_pkg::*;

  logic [4:0]        swm1, dwm1;
  logic [31:0]       smask, dmask;
  logic [31:0]       i2i_v;
  logic [31:0]       t, top;
  logic [31:0]       dhalf;
  logic [7:0]        e;
  logic [23:0]       sig;
  logic signed [9:0] sh;
  logic [4:0]        rsh;
  logic [31:0]       fmag, fr;
  logic [31:0]       direct;
  logic              sgn;
  logic [31:0]       mag;
  logic [4:0]        msb;

  assign swm1  = width_m1(cfg.src_width_code);
  assign dwm1  = width_m1(cfg.dst_width_code);
  assign smask = width_mask(cfg.src_width_code);
  assign dmask = width_mask(cfg.dst_width_code);

  // integer to integer: byte shift then sign bit flip
  always_comb begin
    i2i_v = sample & smask;
    if (dwm1 > swm1) i2i_v = i2i_v << (dwm1 - swm1);
    else if (swm1 > dwm1) i2i_v = i2i_v >> (swm1 - dwm1);
    i2i_v = i2i_v & dmask;
    if (cfg.src_is_signed != cfg.dst_is_signed) i2i_v = i2i_v ^ (32'd1 << dwm1);
  end

  // float to integer: scale, truncate, saturate, offset
  assign dhalf = 32'd1 << dwm1;
  assign e     = sample[30:23];
  assign sig   = {1'b1, sample[22:0]};
  assign sh    = $signed({2'b00, e}) - 10'sd151 + $signed({5'b00000, dwm1});
  assign rsh   = 5'(-sh);

  always_comb begin
    if (e == 8'hFF && sample[22:0] != 23'd0) fmag = 32'd0;
    else if (e == 8'd0) fmag = 32'd0;
    else if (e == 8'hFF || sh >= 10'sd8) fmag = dhalf;
    else if (sh >= 10'sd0) fmag = {8'd0, sig} << sh[2:0];
    else if (sh <= -10'sd24) fmag = 32'd0;
    else fmag = {8'd0, sig} >> rsh;
    if (sample[31]) begin
      if (fmag > dhalf) fmag = dhalf;
      fr = 32'd0 - fmag;
    end else begin
      if (fmag > dhalf - 32'd1) fmag = dhalf - 32'd1;
      fr = fmag;
    end
    if (!cfg.dst_is_signed) fr = fr + dhalf;
    fr = fr & dmask;
  end

  // integer to float: signed magnitude of the source
  assign top = 32'd1 << swm1;
  always_comb begin
    t = sample & smask;
    if (!cfg.src_is_signed) t = t ^ top;
  end

  assign sgn = (t & top) != 32'd0;
  assign mag = sgn ? ((32'd0 - t) & smask) : t;

  // leading one position, highest set bit wins
  always_comb begin
    msb = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) msb = 5'(i);
    end
  end

  // pick the integer result
  always_comb begin
    case (cfg.mode)
      MODE_I2I: direct = i2i_v;
      MODE_F2I: direct = fr;
      default:  direct = 32'd0;
    endcase
  end

  assign mid.mode   = cfg.mode;
  assign mid.direct = direct;
  assign mid.sign   = sgn;
  assign mid.mag    = mag;
  assign mid.msb    = msb;
  assign mid.wm1    = {3'd0, swm1};
endmodule

// File: rtl/pcmfc_pack.sv
// ---------------------------------------------------------------------------
// pcmfc_pack
// Second logic stage: normalise, round to nearest even and pack the float.
// ---------------------------------------------------------------------------
module pcmfc_pack (
  input  pcmfc_pkg::mid_t mid,
  output logic [31:0]     result
);
  import pcmfc_pkg::*;

  logic [31:0] norm;
  logic        rnd;
  logic [24:0] q;
  logic [22:0] mant;
  logic [7:0]  exp_f;

  // leading one to bit 31, low byte holds guard and sticky
  assign norm  = mid.mag << (5'd31 - mid.msb);
  assign rnd   = norm[7] && ((norm[6:0] != 7'd0) || norm[8]);
  assign q     = {1'b0, norm[31:8]} + {24'd0, rnd};
  assign mant  = q[24] ? q[23:1] : q[22:0];
  assign exp_f = EXP_BIAS + {3'd0, mid.msb} + {7'd0, q[24]} - mid.wm1;

  // result select
  always_comb begin
    case (mid.mode)
      MODE_I2F: result = (mid.mag == 32'd0) ? 32'd0 : {mid.sign, exp_f, mant};
      default:  result = mid.direct;
    endcase
  end
endmodule

// File: rtl/pcm_sample_format_converter.sv
// Pipeline: input register, middle register and result register lie between
// an input transfer and the result valid.
// Throughput: one sample per cycle while the output is not stalled; each register
// stage advances when the stage after it is empty or moving.
// Reset clears all stage valid flags and loads the register reset values.
// ---------------------------------------------------------------------------
// pcm_sample_format_converter
// PCM sample conversion between 8/16/32-bit integer formats and single float.
// ---------------------------------------------------------------------------
module pcm_sample_format_converter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [pcmfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmfc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  pcmfc_in_if.sink                         in_ch,
  pcmfc_out_if.source                      out_ch
);
  import pcmfc_pkg::*;

  cfg_t        cfg;
  logic        s1_valid;
  logic [31:0] s1_sample;
  logic        s2_valid;
  mid_t        s2_mid;
  mid_t        mid_next;
  logic        out_valid;
  logic [31:0] out_sample;
  logic [31:0] result_next;
  logic        ld3, ld2, ld1;

  pcmfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pcmfc_prep u_prep (
    .sample (s1_sample),
    .cfg    (cfg),
    .mid    (mid_next)
  );

  pcmfc_pack u_pack (
    .mid    (s2_mid),
    .result (result_next)
  );

  // stage load enables
  assign ld3 = !out_valid || out_ch.ready;
  assign ld2 = !s2_valid || ld3;
  assign ld1 = !s1_valid || ld2;

  assign in_ch.ready       = ld1;
  assign out_ch.valid      = out_valid;
  assign out_ch.out_sample = out_sample;

  // valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ld1) s1_valid  <= in_ch.valid;
      if (ld2) s2_valid  <= s1_valid;
      if (ld3) out_valid <= s2_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ld1) s1_sample  <= in_ch.in_sample;
    if (ld2) s2_mid     <= mid_next;
    if (ld3) out_sample <= result_next;
  end

  // no result straight after reset
  assert property (@(posedge clk) rst |=> !out_ch.valid)
    else $error("result valid after reset");

  // a full pipeline with a stalled output takes no new sample
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid && out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("sample taken while pipeline full and stalled");

  // an accepted sample is held in the input stage after the transfer
  assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> s1_valid)
    else $error("accepted sample lost");

  // a stalled result holds in place while the middle stage stays full
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready && s2_valid) |=> (s2_valid && out_valid))
    else $error("stage dropped while stalled");
endmodule
